// ----- rtl/srte_pkg.sv -----
// Shared types, constants and helpers of the stepper ramp table executor.
package srte_pkg;

	localparam int unsigned TABLE_DEPTH_DEF  = 1024;
	localparam int unsigned STALL_MIN_DEF    = 640;
	localparam int unsigned STALL_PERIOD_DEF = 16;

	// Widths fixed by the request and result fields.
	localparam int STEP_W   = 24;
	localparam int RAMP_W   = 11;
	localparam int CRUISE_W = 20;
	localparam int IVAL_W   = 16;
	localparam int TIME_W   = 32;
	localparam int EIDX_W   = 10;
	localparam int ADDR_MAX_W = 16;

	// Request codes.
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TOTAL_STEPS  = 2'd0;
	localparam logic [1:0] CFG_RAMP_STEPS   = 2'd1;
	localparam logic [1:0] CFG_CRUISE       = 2'd2;
	localparam logic [1:0] CFG_STALL_ENABLE = 2'd3;

	// Choice of the interval that follows a step.
	typedef struct packed {
		logic                  use_tbl;
		logic [ADDR_MAX_W-1:0] addr;
	} ivl_sel_t;

	// Reduces an index below 2048 into the table range. Every index the block
	// forms stays below 2048, so a short shift-and-subtract over the constant
	// depth does the job; for a power-of-two depth it folds down to a mask.
	function automatic logic [ADDR_MAX_W-1:0] tbl_addr(input logic [RAMP_W-1:0] x,
			input int unsigned depth);
		logic [RAMP_W-1:0] r;
		int unsigned       dk;
		r = x;
		for (int k = RAMP_W - 1; k >= 0; k--) begin
			dk = depth << k;
			if (dk < (32'd1 << RAMP_W) && {21'd0, r} >= dk) begin
				r = r - RAMP_W'(dk);
			end
		end
		return ADDR_MAX_W'(r);
	endfunction

endpackage

// ----- rtl/srte_ramp_mem.sv -----
// Ramp interval table: one write port and one registered read port.
module srte_ramp_mem #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [15:0]                wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [15:0]                rd_data
);

	logic [15:0] mem_q [DEPTH];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read, so a later write cannot disturb it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/srte_ivl_sel.sv -----
// Picks the interval source and table address for the step after the current one.
module srte_ivl_sel #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic [srte_pkg::STEP_W-1:0]   step_counter,
	input  logic [srte_pkg::STEP_W-1:0]   move_length,
	input  logic [srte_pkg::RAMP_W-1:0]   ramp_steps,
	input  logic [srte_pkg::CRUISE_W-1:0] cruise_interval_us,
	output srte_pkg::ivl_sel_t            sel
);
	import srte_pkg::*;

	logic              accel;
	logic              decel;
	logic [STEP_W:0]   reach;
	logic [STEP_W-1:0] mirror;
	logic [RAMP_W-1:0] idx;

	assign accel  = step_counter < STEP_W'(ramp_steps);
	assign reach  = {1'b0, step_counter} + (STEP_W + 1)'(ramp_steps);
	assign decel  = reach >= {1'b0, move_length};
	assign mirror = move_length - step_counter - STEP_W'(1);

	// Every table index chosen here is zero or lies below ramp_steps, hence below 2048.
	always_comb begin
		sel.use_tbl = 1'b1;
		idx         = '0;
		if (accel) begin
			idx = step_counter[RAMP_W-1:0];
		end else if (decel) begin
			idx = mirror[RAMP_W-1:0];
		end else if (cruise_interval_us == '0) begin
			idx = (ramp_steps == '0) ? '0 : ramp_steps - RAMP_W'(1);
		end else begin
			sel.use_tbl = 1'b0;
		end
		sel.addr = tbl_addr(idx, TABLE_DEPTH);
	end

endmodule

// ----- rtl/stepper_ramp_table_executor.sv -----
// A request passes the input stage, then the result register, at one per cycle
// unless the output stalls; the interval of a step is read from the table
// in the cycle of that step and added to the schedule when the next request is handled.
// Reset clears the move state, the configuration registers and both handshake stages;
// the ramp table is not cleared and holds nothing defined until it is loaded.
module stepper_ramp_table_executor #(
	parameter int unsigned TABLE_DEPTH        = srte_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned STALL_MIN_STEPS    = srte_pkg::STALL_MIN_DEF,
	parameter int unsigned STALL_CHECK_PERIOD = srte_pkg::STALL_PERIOD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [23:0]                     cfg_data,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      req_type,
	input  logic [srte_pkg::EIDX_W-1:0]     entry_index,
	input  logic [srte_pkg::IVAL_W-1:0]     entry_interval_us,
	input  logic [srte_pkg::TIME_W-1:0]     time_now_us,
	input  logic                            stall_flag,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            step_pulse,
	output logic                            move_done,
	output logic                            stall_abort,
	output logic [srte_pkg::STEP_W-1:0]     steps_done
);
	import srte_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PW = (STALL_CHECK_PERIOD > 1) ? $clog2(STALL_CHECK_PERIOD) : 1;
	localparam logic [PW-1:0] PHASE_LAST = PW'(STALL_CHECK_PERIOD - 1);
	localparam logic [PW-1:0] PHASE_ONE  = PW'(1 % STALL_CHECK_PERIOD);

	// Configuration registers.
	logic [STEP_W-1:0]   total_steps_q;
	logic [RAMP_W-1:0]   ramp_steps_q;
	logic [CRUISE_W-1:0] cruise_q;
	logic                stall_en_q;

	// Input stage.
	logic                s1_valid_q;
	logic [1:0]          req_s1;
	logic [EIDX_W-1:0]   idx_s1;
	logic [IVAL_W-1:0]   ival_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                stall_s1;

	// Move state.
	logic                idle_q;
	logic [STEP_W-1:0]   step_cnt_q;
	logic [STEP_W-1:0]   move_len_q;
	logic [PW-1:0]       phase_q;
	logic [TIME_W-1:0]   base_q;
	logic                use_tbl_q;
	logic [CRUISE_W-1:0] cru_ivl_q;

	// Result register.
	logic                out_valid_q;
	logic                pulse_q;
	logic                done_q;
	logic                abort_q;
	logic [STEP_W-1:0]   steps_q;

	logic                advance;
	logic                fire;
	logic                start_go;
	logic                tick_live;
	logic                finish;
	logic                step_go;
	logic                abort_go;
	logic [TIME_W-1:0]   next_time;
	logic [IVAL_W-1:0]   rd_data;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [ADDR_MAX_W-1:0] wr_addr_full;
	ivl_sel_t            sel;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_steps_q <= '0;
			ramp_steps_q  <= '0;
			cruise_q      <= '0;
			stall_en_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOTAL_STEPS:  total_steps_q <= cfg_data[STEP_W-1:0];
				CFG_RAMP_STEPS:   ramp_steps_q  <= cfg_data[RAMP_W-1:0];
				CFG_CRUISE:       cruise_q      <= cfg_data[CRUISE_W-1:0];
				CFG_STALL_ENABLE: stall_en_q    <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// The input stage moves on whenever the result register is free or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = s1_valid_q && advance;
	assign in_stall = s1_valid_q && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1   <= req_type;
			idx_s1   <= entry_index;
			ival_s1  <= entry_interval_us;
			now_s1   <= time_now_us;
			stall_s1 <= stall_flag;
		end
	end

	srte_ivl_sel #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ivl_sel (
		.step_counter      (step_cnt_q),
		.move_length       (move_len_q),
		.ramp_steps        (ramp_steps_q),
		.cruise_interval_us(cruise_q),
		.sel               (sel)
	);

	// The scheduled time is kept as a base plus the interval fetched at the last step.
	assign next_time = base_q + (use_tbl_q ? TIME_W'(rd_data) : TIME_W'(cru_ivl_q));

	assign start_go  = fire && req_s1 == REQ_START && total_steps_q != '0;
	assign tick_live = fire && req_s1 == REQ_TICK && !idle_q;
	assign finish    = tick_live && step_cnt_q >= move_len_q;
	assign step_go   = tick_live && !finish && now_s1 > next_time;
	assign abort_go  = step_go && stall_en_q && stall_s1 && phase_q == PHASE_LAST
		&& step_cnt_q >= STEP_W'(STALL_MIN_STEPS);

	assign rd_en        = start_go || (step_go && sel.use_tbl);
	assign rd_addr      = start_go ? '0 : sel.addr[AW-1:0];
	assign wr_addr_full = tbl_addr(RAMP_W'(idx_s1), TABLE_DEPTH);

	srte_ramp_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_ramp_mem (
		.clk    (clk),
		.wr_en  (fire && req_s1 == REQ_LOAD),
		.wr_addr(wr_addr_full[AW-1:0]),
		.wr_data(ival_s1),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q     <= 1'b1;
			step_cnt_q <= '0;
			move_len_q <= '0;
			phase_q    <= '0;
			base_q     <= '0;
			use_tbl_q  <= 1'b0;
			cru_ivl_q  <= '0;
		end else if (start_go) begin
			idle_q     <= 1'b0;
			step_cnt_q <= STEP_W'(1);
			move_len_q <= total_steps_q;
			phase_q    <= PHASE_ONE;
			base_q     <= now_s1;
			use_tbl_q  <= 1'b1;
		end else if (finish || abort_go) begin
			idle_q     <= 1'b1;
			step_cnt_q <= '0;
			move_len_q <= '0;
			phase_q    <= '0;
		end else if (step_go) begin
			step_cnt_q <= step_cnt_q + STEP_W'(1);
			phase_q    <= (phase_q == PHASE_LAST) ? '0 : phase_q + PW'(1);
			base_q     <= next_time;
			use_tbl_q  <= sel.use_tbl;
			cru_ivl_q  <= cruise_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	// The result reflects the move state as this request leaves it.
	always_ff @(posedge clk) begin
		if (fire) begin
			pulse_q <= start_go || step_go;
			abort_q <= abort_go;
			if (start_go) begin
				done_q  <= 1'b0;
				steps_q <= STEP_W'(1);
			end else if (finish || abort_go) begin
				done_q  <= 1'b1;
				steps_q <= '0;
			end else if (step_go) begin
				done_q  <= 1'b0;
				steps_q <= step_cnt_q + STEP_W'(1);
			end else begin
				done_q  <= idle_q;
				steps_q <= step_cnt_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign step_pulse  = pulse_q;
	assign move_done   = done_q;
	assign stall_abort = abort_q;
	assign steps_done  = steps_q;

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		idle_q |-> (step_cnt_q == '0 && move_len_q == '0))
		else $error("idle move with a non-zero step count or length");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!idle_q |-> (step_cnt_q <= move_len_q && step_cnt_q != '0))
		else $error("step count outside the move length");

	a_abort_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stall_abort) |-> (step_pulse && move_done && steps_done == '0))
		else $error("stall abort result is inconsistent");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_go, finish, step_go}))
		else $error("more than one move action in a cycle");

endmodule

// ----- tb/tb_stepper_ramp_table_executor.sv -----
// Self-checking testbench for the stepper ramp table executor with a scoreboard class.
`timescale 1ns / 1ps

typedef struct packed {
	logic [1:0]  kind;
	logic [9:0]  idx;
	logic [15:0] ival;
	logic [31:0] now;
	logic        stall;
} ramp_req_t;

typedef struct packed {
	logic        pulse;
	logic        done;
	logic        aborted;
	logic [23:0] steps;
} step_res_t;

// Predicts the step output of every request and checks the results in order.
class ramp_play_model;
	logic [15:0] ramp_tbl [srte_pkg::TABLE_DEPTH_DEF];
	bit          loaded [srte_pkg::TABLE_DEPTH_DEF];
	bit          at_rest;
	logic [23:0] step_cnt;
	logic [23:0] move_len;
	logic [31:0] next_due;
	logic [23:0] cfg_total;
	logic [10:0] cfg_ramp;
	logic [19:0] cfg_cruise;
	logic        cfg_stall_en;
	step_res_t   expected_q[$];
	int          errors, n_results, n_requests, n_steps, n_finished, n_aborts;

	function new();
		foreach (ramp_tbl[i]) begin
			ramp_tbl[i] = '0;
			loaded[i]   = 1'b0;
		end
		at_rest      = 1'b1;
		step_cnt     = '0;
		move_len     = '0;
		next_due     = '0;
		cfg_total    = '0;
		cfg_ramp     = '0;
		cfg_cruise   = '0;
		cfg_stall_en = 1'b0;
		errors       = 0;
		n_results    = 0;
		n_requests   = 0;
		n_steps      = 0;
		n_finished   = 0;
		n_aborts     = 0;
	endfunction

	function void report(string what);
		errors++;
		if (errors <= 50)
			$display("MISMATCH at %0t: %s", $time, what);
	endfunction

	function void set_register(logic [1:0] idx, logic [23:0] data);
		case (idx)
			srte_pkg::CFG_TOTAL_STEPS:  cfg_total    = data;
			srte_pkg::CFG_RAMP_STEPS:   cfg_ramp     = data[10:0];
			srte_pkg::CFG_CRUISE:       cfg_cruise   = data[19:0];
			srte_pkg::CFG_STALL_ENABLE: cfg_stall_en = data[0];
			default: ;
		endcase
	endfunction

	function int unsigned tbl_at(int unsigned x);
		return ramp_tbl[x % srte_pkg::TABLE_DEPTH_DEF];
	endfunction

	// Interval to the step after the current one: ramp up, ramp down mirrored,
	// last ramp entry when there is no plateau, else the plateau interval.
	function int unsigned next_gap();
		int unsigned sc, ml, rs;
		sc = step_cnt;
		ml = move_len;
		rs = cfg_ramp;
		if (sc < rs)
			return tbl_at(sc);
		if (sc + rs >= ml)
			return tbl_at(ml - sc - 1);
		if (cfg_cruise == 0)
			return tbl_at(rs == 0 ? 0 : rs - 1);
		return cfg_cruise;
	endfunction

	function void apply_request(ramp_req_t r);
		step_res_t e;
		e = '0;
		n_requests++;
		case (r.kind)
			srte_pkg::REQ_LOAD: begin
				ramp_tbl[r.idx] = r.ival;
				loaded[r.idx]   = 1'b1;
			end
			srte_pkg::REQ_START: begin
				if (cfg_total != 0) begin
					move_len = cfg_total;
					step_cnt = 24'd1;
					at_rest  = 1'b0;
					next_due = r.now + 32'(tbl_at(0));
					e.pulse  = 1'b1;
					n_steps++;
				end
			end
			srte_pkg::REQ_TICK: begin
				if (!at_rest) begin
					if (step_cnt >= move_len) begin
						move_len = '0;
						step_cnt = '0;
						at_rest  = 1'b1;
						n_finished++;
					end else if (r.now > next_due) begin
						next_due = next_due + 32'(next_gap());
						step_cnt = step_cnt + 24'd1;
						e.pulse  = 1'b1;
						n_steps++;
						if (cfg_stall_en && step_cnt % srte_pkg::STALL_PERIOD_DEF == 0 &&
								step_cnt > srte_pkg::STALL_MIN_DEF && r.stall) begin
							move_len  = '0;
							step_cnt  = '0;
							at_rest   = 1'b1;
							e.aborted = 1'b1;
							n_aborts++;
						end
					end
				end
			end
			default: ;
		endcase
		e.done  = at_rest;
		e.steps = step_cnt;
		expected_q.push_back(e);
	endfunction

	function void check_result(step_res_t got);
		step_res_t want;
		n_results++;
		if (expected_q.size() == 0) begin
			report($sformatf("result %0d arrived with no request pending", n_results));
			return;
		end
		want = expected_q.pop_front();
		if (got.pulse !== want.pulse)
			report($sformatf("result %0d step_pulse %b, expected %b",
				n_results, got.pulse, want.pulse));
		if (got.done !== want.done)
			report($sformatf("result %0d move_done %b, expected %b",
				n_results, got.done, want.done));
		if (got.aborted !== want.aborted)
			report($sformatf("result %0d stall_abort %b, expected %b",
				n_results, got.aborted, want.aborted));
		if (got.steps !== want.steps)
			report($sformatf("result %0d steps_done %0d, expected %0d",
				n_results, got.steps, want.steps));
	endfunction
endclass

module tb_stepper_ramp_table_executor;

	localparam logic [1:0] REQ_NONE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [9:0]  entry_index;
	logic [15:0] entry_interval_us;
	logic [31:0] time_now_us;
	logic        stall_flag;
	logic        out_valid;
	logic        out_stall;
	logic        step_pulse;
	logic        move_done;
	logic        stall_abort;
	logic [23:0] steps_done;

	int tx_idle_pct;
	int rx_stall_pct;
	int n_settings;

	ramp_play_model model;

	stepper_ramp_table_executor dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.entry_index       (entry_index),
		.entry_interval_us (entry_interval_us),
		.time_now_us       (time_now_us),
		.stall_flag        (stall_flag),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.step_pulse        (step_pulse),
		.move_done         (move_done),
		.stall_abort       (stall_abort),
		.steps_done        (steps_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			model.check_result({step_pulse, move_done, stall_abort, steps_done});
	end

	task automatic send(input ramp_req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid          <= 1'b1;
		req_type          <= r.kind;
		entry_index       <= r.idx;
		entry_interval_us <= r.ival;
		time_now_us       <= r.now;
		stall_flag        <= r.stall;
		do @(posedge clk); while (in_stall);
		model.apply_request(r);
	endtask

	task automatic send_f(input logic [1:0] kind, input logic [9:0] idx,
			input logic [15:0] ival, input logic [31:0] now, input logic stall);
		send('{kind, idx, ival, now, stall});
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (model.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		model.set_register(idx, data);
	endtask

	// Registers change only once the pipeline is empty. Afterwards every table
	// entry that a move can read under the new ramp length is loaded.
	task automatic configure(input int unsigned total, input int unsigned ramp,
			input int unsigned cruise, input bit stall_en);
		int unsigned span;
		wait_results();
		cfg_write(srte_pkg::CFG_TOTAL_STEPS, 24'(total));
		cfg_write(srte_pkg::CFG_RAMP_STEPS, 24'(ramp));
		cfg_write(srte_pkg::CFG_CRUISE, 24'(cruise));
		cfg_write(srte_pkg::CFG_STALL_ENABLE, 24'(stall_en));
		cfg_valid <= 1'b0;
		n_settings++;
		span = (ramp == 0) ? 1 : ramp;
		for (int i = 0; i < span; i++)
			if (!model.loaded[i])
				send_f(srte_pkg::REQ_LOAD, 10'(i),
					($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 50000)) :
					16'($urandom_range(1, 1500)), $urandom, $urandom_range(0, 1));
	endtask

	// Tick times mostly land past the scheduled step so moves make progress.
	function automatic logic [31:0] tick_time();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 72)
			return model.next_due + 32'($urandom_range(1, 3000));
		if (pick < 80)
			return model.next_due;
		if (pick < 88)
			return model.next_due - 32'($urandom_range(1, 500));
		return $urandom;
	endfunction

	function automatic ramp_req_t random_request();
		ramp_req_t r;
		int        pick;
		r.kind  = srte_pkg::REQ_TICK;
		r.idx   = $urandom_range(0, 1023);
		r.ival  = $urandom_range(0, 50000);
		r.now   = $urandom;
		r.stall = $urandom_range(0, 1);
		pick    = $urandom_range(0, 99);
		if (pick < 6)
			r.kind = srte_pkg::REQ_LOAD;
		else if (pick < 9)
			r.kind = REQ_NONE;
		else if (pick < 14 || (model.at_rest && pick < 45))
			r.kind = srte_pkg::REQ_START;
		else
			r.now = tick_time();
		return r;
	endfunction

	task automatic run_phase(input int unsigned total, input int unsigned ramp,
			input int unsigned cruise, input bit stall_en, input int n);
		configure(total, ramp, cruise, stall_en);
		repeat (n) send(random_request());
	endtask

	// One long move with the stall check on and no restarts, so that the step
	// count gets past the point where a stall may abort it.
	task automatic run_stall_move();
		int n;
		int pick;
		configure(800, 40, 250, 1'b1);
		send_f(srte_pkg::REQ_START, $urandom, $urandom, $urandom, 1'b0);
		n = 0;
		while (!model.at_rest && n < 1500) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				send_f(srte_pkg::REQ_LOAD, $urandom, $urandom_range(0, 50000), $urandom,
					$urandom_range(0, 1));
			else if (pick < 6)
				send_f(REQ_NONE, $urandom, $urandom, $urandom, $urandom_range(0, 1));
			else
				send_f(srte_pkg::REQ_TICK, $urandom, $urandom,
					($urandom_range(0, 99) < 90) ?
					model.next_due + 32'($urandom_range(1, 3000)) : tick_time(),
					$urandom_range(0, 3) == 0);
			n++;
		end
	endtask

	initial begin
		model = new();
		arst_n            <= 1'b0;
		cfg_valid         <= 1'b0;
		cfg_index         <= '0;
		cfg_data          <= '0;
		in_valid          <= 1'b0;
		req_type          <= '0;
		entry_index       <= '0;
		entry_interval_us <= '0;
		time_now_us       <= '0;
		stall_flag        <= 1'b0;
		out_stall         <= 1'b0;
		n_settings        = 0;
		tx_idle_pct       = 38;
		rx_stall_pct      = 72;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: table extremes, idle requests, a move across the time wrap,
		// a finish, and a restart during a move.
		send_f(srte_pkg::REQ_LOAD, 10'd0, 16'd50000, 32'd0, 1'b0);
		send_f(srte_pkg::REQ_LOAD, 10'd1, 16'd0, 32'hFFFF_FFFF, 1'b1);
		send_f(srte_pkg::REQ_LOAD, 10'd1023, 16'd50000, 32'd0, 1'b0);
		send_f(srte_pkg::REQ_LOAD, 10'd512, 16'd32768, 32'd0, 1'b0);
		configure(0, 2, 0, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'd0, 1'b0);
		send_f(REQ_NONE, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_f(srte_pkg::REQ_START, 10'd0, 16'd0, 32'd1000, 1'b0);
		configure(3, 2, 0, 1'b0);
		send_f(srte_pkg::REQ_START, 10'd0, 16'd0, 32'hFFFF_FFF0, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'h0000_C340, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'h0000_C33F, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'h0000_C341, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'h0000_C341, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'hFFFF_FFFF, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'hFFFF_FFFF, 1'b0);
		send_f(srte_pkg::REQ_START, 10'd0, 16'd0, 32'd0, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'hFFFF_FFFF, 1'b1);
		send_f(srte_pkg::REQ_START, 10'd0, 16'd0, 32'd100, 1'b0);
		send_f(srte_pkg::REQ_TICK, 10'd0, 16'd0, 32'h0001_0000, 1'b0);

		run_phase(30, 5, 700, 1'b0, 110);
		run_phase(12, 20, 300, 1'b1, 80);
		run_phase(25, 6, 0, 1'b0, 80);

		tx_idle_pct  = 72;
		rx_stall_pct = 38;
		run_phase(15, 0, 0, 1'b0, 60);
		run_phase(20, 0, 1000000, 1'b1, 60);
		run_phase(16777215, 1024, 0, 1'b1, 60);
		run_stall_move();

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		run_phase(1, 1, 5, 1'b0, 50);
		run_phase(0, 3, 0, 1'b0, 30);
		run_phase(40, 8, 1200, 1'b1, 120);

		wait_results();
		repeat (10) @(posedge clk);
		foreach (model.expected_q[i])
			model.report($sformatf("expected result %0d never arrived", i));
		$display("Covered %0d requests under %0d register settings:", model.n_requests,
			n_settings);
		$display("%0d steps issued, %0d moves run to the end, %0d stall aborts.",
			model.n_steps, model.n_finished, model.n_aborts);
		if (model.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
